[rtl/mi3_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared types and cofactor index tables for the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
package mi3_pkg;

  // Per-request control handed to each divider lane at its entry stage.
  typedef struct packed {
    logic advance;
    logic invertible;
    logic negative;
  } lane_ctl_t;

  // Cofactor k = m[A]*m[B] - m[C]*m[D], elements indexed row*3+col.
  localparam int unsigned COF_A [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned COF_B [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned COF_C [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int unsigned COF_D [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage
`default_nettype wire

[rtl/mi3_cofactor.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_cofactor
// One adjugate term a*b - c*d, two pipeline stages.
// ----------------------------------------------------------------------------
module mi3_cofactor #(
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           advance,
  input  wire logic signed [DATA_WIDTH-1:0]   a,
  input  wire logic signed [DATA_WIDTH-1:0]   b,
  input  wire logic signed [DATA_WIDTH-1:0]   c,
  input  wire logic signed [DATA_WIDTH-1:0]   d,
  output logic signed      [2*DATA_WIDTH:0]   adj
);

  localparam int PW = 2 * DATA_WIDTH;

  logic signed [PW-1:0] p0;
  logic signed [PW-1:0] p1;

  always_ff @(posedge clk) begin
    if (advance) begin
      p0  <= a * b;
      p1  <= c * d;
      adj <= (PW+1)'(p0) - (PW+1)'(p1);
    end
  end

endmodule
`default_nettype wire

[rtl/mi3_div_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_div_lane
// Pipelined restoring divider lane: rounded adj * 2^(2F) / det, one quotient
// bit per stage, then rounding, saturation and singular-path select.
// ----------------------------------------------------------------------------
module mi3_div_lane #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 12
) (
  input  wire logic                          clk,
  input  wire mi3_pkg::lane_ctl_t            ctl,
  input  wire logic [2*DATA_WIDTH-1:0]       num,
  input  wire logic [3*DATA_WIDTH+2:0]       den,
  input  wire logic [DATA_WIDTH-1:0]         alt_field,
  input  wire logic                          alt_sat,
  output logic      [DATA_WIDTH-1:0]         field,
  output logic                               sat
);

  localparam int DW    = DATA_WIDTH;
  localparam int DET_W = 3 * DW + 3;
  localparam int QW    = DW + 1;
  localparam int REM_W = DET_W + QW;

  localparam logic [QW-1:0] LIM_NEG = QW'(1) << (DW - 1);
  localparam logic [QW-1:0] LIM_POS = LIM_NEG - QW'(1);
  localparam logic [DW-1:0] FMIN    = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] FMAX    = {1'b0, {(DW-1){1'b1}}};

  logic [REM_W-1:0] p_rem  [QW];
  logic [DET_W-1:0] p_den  [QW];
  logic [QW-1:0]    p_q    [QW+1];
  logic             p_ovf  [QW+1];
  logic             p_inv  [QW+1];
  logic             p_neg  [QW+1];
  logic [DW-1:0]    p_alt  [QW+1];
  logic             p_asat [QW+1];

  logic [REM_W-1:0] n_ext;
  logic [QW:0]      q_inc;
  logic [QW-1:0]    r;
  logic             r_sat;
  logic [DW-1:0]    r_field;

  assign n_ext = REM_W'(num) << (2 * FRAC_BITS + 1);

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      p_rem[0]  <= n_ext;
      p_den[0]  <= den;
      p_q[0]    <= '0;
      p_ovf[0]  <= n_ext >= (REM_W'(den) << QW);
      p_inv[0]  <= ctl.invertible;
      p_neg[0]  <= ctl.negative;
      p_alt[0]  <= alt_field;
      p_asat[0] <= alt_sat;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_step
    localparam int B = QW - 1 - s;
    logic [REM_W-1:0] sub;
    logic             ge;
    assign sub = REM_W'(p_den[s]) << B;
    assign ge  = p_rem[s] >= sub;

    always_ff @(posedge clk) begin
      if (ctl.advance) begin
        p_q[s+1]    <= {p_q[s][QW-2:0], ge};
        p_ovf[s+1]  <= p_ovf[s];
        p_inv[s+1]  <= p_inv[s];
        p_neg[s+1]  <= p_neg[s];
        p_alt[s+1]  <= p_alt[s];
        p_asat[s+1] <= p_asat[s];
      end
    end

    if (s < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (ctl.advance) begin
          p_rem[s+1] <= ge ? p_rem[s] - sub : p_rem[s];
          p_den[s+1] <= p_den[s];
        end
      end
    end
  end

  always_comb begin
    q_inc   = (QW+1)'(p_q[QW]) + (QW+1)'(1);
    r       = q_inc[QW:1];
    r_sat   = p_ovf[QW] || (r > (p_neg[QW] ? LIM_NEG : LIM_POS));
    r_field = p_neg[QW] ? (DW'(0) - r[DW-1:0]) : r[DW-1:0];
    if (r_sat) begin
      r_field = p_neg[QW] ? FMIN : FMAX;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      field <= p_inv[QW] ? r_field : p_alt[QW];
      sat   <= p_inv[QW] ? r_sat : p_asat[QW];
    end
  end

endmodule
`default_nettype wire

[rtl/matrix_inverse_3x3.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// 3x3 fixed-point matrix inverse by adjugate and determinant.
// ----------------------------------------------------------------------------
// Takes one matrix per cycle while the output is not stalled and returns one
// result per matrix, in order. Nine cofactor lanes form the adjugate, merge
// stages form the determinant and the singular decision, and nine divider
// lanes then produce one quotient bit per pipeline stage, which sets the
// latency. A stalled output freezes the whole pipeline.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 12
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [DATA_WIDTH-2:0]        singular_tolerance,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [DATA_WIDTH-1:0] a_00,
  input  wire logic signed [DATA_WIDTH-1:0] a_01,
  input  wire logic signed [DATA_WIDTH-1:0] a_02,
  input  wire logic signed [DATA_WIDTH-1:0] a_10,
  input  wire logic signed [DATA_WIDTH-1:0] a_11,
  input  wire logic signed [DATA_WIDTH-1:0] a_12,
  input  wire logic signed [DATA_WIDTH-1:0] a_20,
  input  wire logic signed [DATA_WIDTH-1:0] a_21,
  input  wire logic signed [DATA_WIDTH-1:0] a_22,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0]      inv_00,
  output logic signed [DATA_WIDTH-1:0]      inv_01,
  output logic signed [DATA_WIDTH-1:0]      inv_02,
  output logic signed [DATA_WIDTH-1:0]      inv_10,
  output logic signed [DATA_WIDTH-1:0]      inv_11,
  output logic signed [DATA_WIDTH-1:0]      inv_12,
  output logic signed [DATA_WIDTH-1:0]      inv_20,
  output logic signed [DATA_WIDTH-1:0]      inv_21,
  output logic signed [DATA_WIDTH-1:0]      inv_22,
  output logic                              invertible,
  output logic signed [DATA_WIDTH-1:0]      determinant,
  output logic                              saturated
);

  localparam int DW    = DATA_WIDTH;
  localparam int AW    = 2 * DW;
  localparam int ADJ_W = 2 * DW + 1;
  localparam int DP_W  = 3 * DW + 1;
  localparam int DET_W = 3 * DW + 3;
  localparam int QW    = DW + 1;
  localparam int LAT   = QW + 7;

  localparam logic [DW:0]   LIM_NEG = (DW+1)'(1) << (DW - 1);
  localparam logic [DW:0]   LIM_POS = LIM_NEG - (DW+1)'(1);
  localparam logic [DW-1:0] FMIN    = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] FMAX    = {1'b0, {(DW-1){1'b1}}};

  logic [DW-2:0] tolerance;
  logic [LAT-1:0] vld;
  logic advance;

  logic signed [DW-1:0]    m     [9];
  logic signed [DW-1:0]    r0a   [3];
  logic signed [DW-1:0]    r0b   [3];
  logic signed [ADJ_W-1:0] adj2  [9];
  logic signed [ADJ_W-1:0] adj3  [9];
  logic signed [ADJ_W-1:0] adj4  [9];
  logic signed [DP_W-1:0]  dp3   [3];
  logic signed [DET_W-1:0] det4;
  logic [DET_W-1:0]        dmag5;
  logic                    dneg5;
  logic [AW-1:0]           amag5 [9];
  logic                    aneg5 [9];

  logic [ADJ_W-1:0]        adj_abs [9];
  logic [AW:0]             a_sum   [9];
  logic [AW:0]             a_r     [9];
  logic [DW-1:0]           alt_f   [9];
  logic                    alt_s   [9];
  logic                    inv_c;
  logic [DET_W:0]          d_sum;
  logic [DET_W:0]          d_r;
  logic [DW-1:0]           detf_c;
  logic                    dsat_c;

  logic                    inv_d  [QW+2];
  logic [DW-1:0]           detf_d [QW+2];
  logic                    dsat_d [QW+2];

  logic [DW-1:0]           lane_f [9];
  logic                    lane_s [9];
  mi3_pkg::lane_ctl_t      ctl    [9];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= (DW-1)'(1);
    end else if (cfg_valid && cfg_ready) begin
      tolerance <= singular_tolerance;
    end
  end

  assign out_valid = vld[LAT-1];
  assign advance   = !vld[LAT-1] || !out_stall;
  assign in_stall  = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  assign m[0] = a_00;
  assign m[1] = a_01;
  assign m[2] = a_02;
  assign m[3] = a_10;
  assign m[4] = a_11;
  assign m[5] = a_12;
  assign m[6] = a_20;
  assign m[7] = a_21;
  assign m[8] = a_22;

  for (genvar k = 0; k < 9; k++) begin : g_cof
    mi3_cofactor #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cof (
      .clk    (clk),
      .advance(advance),
      .a      (m[mi3_pkg::COF_A[k]]),
      .b      (m[mi3_pkg::COF_B[k]]),
      .c      (m[mi3_pkg::COF_C[k]]),
      .d      (m[mi3_pkg::COF_D[k]]),
      .adj    (adj2[k])
    );
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int j = 0; j < 3; j++) begin
        r0a[j] <= m[j];
        r0b[j] <= r0a[j];
        dp3[j] <= r0b[j] * adj2[3*j];
      end
      for (int k = 0; k < 9; k++) begin
        adj3[k]  <= adj2[k];
        adj4[k]  <= adj3[k];
        amag5[k] <= adj_abs[k][AW-1:0];
        aneg5[k] <= adj4[k][ADJ_W-1];
      end
      det4  <= DET_W'(dp3[0]) + DET_W'(dp3[1]) + DET_W'(dp3[2]);
      dmag5 <= det4[DET_W-1] ? DET_W'(-det4) : DET_W'(det4);
      dneg5 <= det4[DET_W-1];
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      adj_abs[k] = adj4[k][ADJ_W-1] ? ADJ_W'(-adj4[k]) : ADJ_W'(adj4[k]);
      a_sum[k]   = (AW+1)'(amag5[k]) + ((AW+1)'(1) << (FRAC_BITS - 1));
      a_r[k]     = a_sum[k] >> FRAC_BITS;
      alt_s[k]   = a_r[k] > (AW+1)'(aneg5[k] ? LIM_NEG : LIM_POS);
      alt_f[k]   = aneg5[k] ? (DW'(0) - a_r[k][DW-1:0]) : a_r[k][DW-1:0];
      if (alt_s[k]) begin
        alt_f[k] = aneg5[k] ? FMIN : FMAX;
      end
    end
    inv_c  = dmag5 > (DET_W'(tolerance) << (2 * FRAC_BITS));
    d_sum  = (DET_W+1)'(dmag5) + ((DET_W+1)'(1) << (2 * FRAC_BITS - 1));
    d_r    = d_sum >> (2 * FRAC_BITS);
    dsat_c = d_r > (DET_W+1)'(dneg5 ? LIM_NEG : LIM_POS);
    detf_c = dneg5 ? (DW'(0) - d_r[DW-1:0]) : d_r[DW-1:0];
    if (dsat_c) begin
      detf_c = dneg5 ? FMIN : FMAX;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      inv_d[0]  <= inv_c;
      detf_d[0] <= detf_c;
      dsat_d[0] <= dsat_c;
      for (int i = 1; i < QW + 2; i++) begin
        inv_d[i]  <= inv_d[i-1];
        detf_d[i] <= detf_d[i-1];
        dsat_d[i] <= dsat_d[i-1];
      end
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_lane
    assign ctl[k] = '{advance: advance, invertible: inv_c, negative: aneg5[k] ^ dneg5};

    mi3_div_lane #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk      (clk),
      .ctl      (ctl[k]),
      .num      (amag5[k]),
      .den      (dmag5),
      .alt_field(alt_f[k]),
      .alt_sat  (alt_s[k]),
      .field    (lane_f[k]),
      .sat      (lane_s[k])
    );
  end

  assign inv_00      = lane_f[0];
  assign inv_01      = lane_f[1];
  assign inv_02      = lane_f[2];
  assign inv_10      = lane_f[3];
  assign inv_11      = lane_f[4];
  assign inv_12      = lane_f[5];
  assign inv_20      = lane_f[6];
  assign inv_21      = lane_f[7];
  assign inv_22      = lane_f[8];
  assign invertible  = inv_d[QW+1];
  assign determinant = detf_d[QW+1];
  assign saturated   = dsat_d[QW+1] | lane_s[0] | lane_s[1] | lane_s[2] | lane_s[3]
                     | lane_s[4] | lane_s[5] | lane_s[6] | lane_s[7] | lane_s[8];

`ifndef ASSERT_OFF
  a_stall_only_when_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output is free");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");
`endif

endmodule
`default_nettype wire
